@@ rtl/core/two_view_density_texel_sampler_defines.svh @@
// Assertion macros for the two-view density texel sampler.
// Used by the port checker; needs a clock and reset in scope.
`ifndef TWO_VIEW_DENSITY_TEXEL_SAMPLER_DEFINES_SVH
`define TWO_VIEW_DENSITY_TEXEL_SAMPLER_DEFINES_SVH

// consequent checked in the same cycle
`define TVDTS_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// consequent checked in the next cycle
`define TVDTS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/tvdts_pkg.sv @@
// Shared types and constants of the two-view density texel sampler.
// No dependencies.
`default_nettype none

package tvdts_pkg;

   localparam int TOP_WIDTH_DEF   = 256;
   localparam int TOP_HEIGHT_DEF  = 256;
   localparam int SIDE_WIDTH_DEF  = 256;
   localparam int SIDE_HEIGHT_DEF = 256;
   localparam int CHANNELS_DEF    = 4;

   localparam int ADDR_W  = 18;
   localparam int IDX_W   = 12;
   localparam int NUM_W   = 34;
   localparam int DEN_W   = 32;
   localparam int ROOT_W  = 32;
   localparam int LANES   = 4;
   localparam int PADDR_W = 5;

   localparam logic [2:0] REG_BOX_MIN_X  = 3'd0;
   localparam logic [2:0] REG_BOX_MIN_Z  = 3'd1;
   localparam logic [2:0] REG_BOX_SPAN_X = 3'd2;
   localparam logic [2:0] REG_BOX_SPAN_Y = 3'd3;
   localparam logic [2:0] REG_BOX_SPAN_Z = 3'd4;

   typedef enum logic [1:0] {
      OP_SAMPLE     = 2'd0,
      OP_WRITE_TOP  = 2'd1,
      OP_WRITE_SIDE = 2'd2,
      OP_IGNORE     = 2'd3
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [1:0]        ch;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        value;
   } item_type;

   typedef struct packed {
      item_type          item;
      logic [NUM_W-1:0]  relx;
      logic [NUM_W-1:0]  relz;
      logic [NUM_W-1:0]  ynum;
   } sqrt_side_type;

endpackage

`default_nettype wire

@@ rtl/core/tvdts_image_ram.sv @@
// Byte image store, one port, registered read.
// Depends on tvdts_pkg.
`default_nettype none

module tvdts_image_ram (
   input  wire logic                        clock,
   input  wire logic                        en,
   input  wire logic                        we,
   input  wire logic [tvdts_pkg::ADDR_W-1:0] addr,
   input  wire logic [7:0]                  wdata,
   output logic      [7:0]                  rdata
);

   logic [7:0] mem [2**tvdts_pkg::ADDR_W];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ rtl/core/tvdts_isqrt.sv @@
// Pipelined integer square root, one result bit per stage, 32 stages.
// Depends on tvdts_pkg.
`default_nettype none

module tvdts_isqrt (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     advance,
   input  wire logic                     in_valid,
   input  wire logic [63:0]              in_n,
   input  tvdts_pkg::sqrt_side_type      in_side,
   output logic                          out_valid,
   output logic [tvdts_pkg::ROOT_W-1:0]  out_root,
   output tvdts_pkg::sqrt_side_type      out_side
);

   localparam int STEPS = tvdts_pkg::ROOT_W;

   logic [STEPS-1:0]         valid_ff, valid_in;
   logic [63:0]              n_ff [STEPS], n_in [STEPS];
   logic [63:0]              res_ff [STEPS], res_in [STEPS];
   tvdts_pkg::sqrt_side_type side_ff [STEPS], side_in [STEPS];

   always_comb begin
      logic [63:0] src_n;
      logic [63:0] src_res;
      logic [63:0] bitv;
      logic [64:0] sum;
      logic        ge;
      for (int k = 0; k < STEPS; k++) begin
         if (k == 0) begin
            src_n      = in_n;
            src_res    = '0;
            valid_in[k] = in_valid;
            side_in[k]  = in_side;
         end else begin
            src_n      = n_ff[k-1];
            src_res    = res_ff[k-1];
            valid_in[k] = valid_ff[k-1];
            side_in[k]  = side_ff[k-1];
         end
         bitv = 64'(1) << (62 - 2*k);
         sum  = 65'(src_res) + 65'(bitv);
         ge   = 65'(src_n) >= sum;
         n_in[k]   = ge ? (src_n - sum[63:0]) : src_n;
         res_in[k] = ge ? ((src_res >> 1) + bitv) : (src_res >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         n_ff    <= n_in;
         res_ff  <= res_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_root  = res_ff[STEPS-1][tvdts_pkg::ROOT_W-1:0];
   assign out_side  = side_ff[STEPS-1];

endmodule

`default_nettype wire

@@ rtl/core/tvdts_index_unit.sv @@
// Four-lane pipelined scaled-index divider with clamping.
// Depends on tvdts_pkg.
`default_nettype none

module tvdts_index_unit #(
   parameter int TOP_WIDTH   = tvdts_pkg::TOP_WIDTH_DEF,
   parameter int TOP_HEIGHT  = tvdts_pkg::TOP_HEIGHT_DEF,
   parameter int SIDE_WIDTH  = tvdts_pkg::SIDE_WIDTH_DEF,
   parameter int SIDE_HEIGHT = tvdts_pkg::SIDE_HEIGHT_DEF
) (
   input  wire logic                                              clock,
   input  wire logic                                              reset,
   input  wire logic                                              advance,
   input  wire logic                                              in_valid,
   input  tvdts_pkg::item_type                                    in_item,
   input  wire logic [tvdts_pkg::LANES-1:0][tvdts_pkg::NUM_W-1:0] in_num,
   input  wire logic [tvdts_pkg::LANES-1:0][tvdts_pkg::DEN_W-1:0] in_den,
   output logic                                                   out_valid,
   output tvdts_pkg::item_type                                    out_item,
   output logic      [tvdts_pkg::LANES-1:0][tvdts_pkg::IDX_W-1:0] out_index
);

   localparam int LANES = tvdts_pkg::LANES;
   localparam int IW    = tvdts_pkg::IDX_W;
   localparam int NW    = tvdts_pkg::NUM_W;
   localparam int DW    = tvdts_pkg::DEN_W;
   localparam int PW    = DW + IW;
   localparam int STEPS = IW;

   localparam logic [LANES-1:0][IW-1:0] SIZE_M1 = {
      IW'(SIDE_HEIGHT - 1), IW'(SIDE_WIDTH - 1), IW'(TOP_HEIGHT - 1), IW'(TOP_WIDTH - 1)
   };

   logic [STEPS:0]                valid_ff, valid_in;
   tvdts_pkg::item_type           item_ff [STEPS+1], item_in [STEPS+1];
   logic [LANES-1:0]              zero_ff [STEPS+1], zero_in [STEPS+1];
   logic [LANES-1:0]              max_ff [STEPS+1], max_in [STEPS+1];
   logic [LANES-1:0][DW-1:0]      rem_ff [STEPS+1], rem_in [STEPS+1];
   logic [LANES-1:0][IW-1:0]      low_ff [STEPS+1], low_in [STEPS+1];
   logic [LANES-1:0][IW-1:0]      q_ff [STEPS+1], q_in [STEPS+1];

   always_comb begin
      logic [NW-1:0] num;
      logic          pos;
      logic [PW-1:0] prod;
      logic [DW:0]   t;
      logic          ge;
      valid_in[0] = in_valid;
      item_in[0]  = in_item;
      for (int l = 0; l < LANES; l++) begin
         num  = in_num[l];
         pos  = !num[NW-1] && (num != '0);
         prod = PW'(num[DW-1:0]) * PW'(SIZE_M1[l]);
         zero_in[0][l] = !pos;
         max_in[0][l]  = pos && ((in_den[l] == '0) || (num >= NW'(in_den[l])));
         rem_in[0][l]  = prod[PW-1:IW];
         low_in[0][l]  = prod[IW-1:0];
         q_in[0][l]    = '0;
      end
      for (int k = 1; k <= STEPS; k++) begin
         valid_in[k] = valid_ff[k-1];
         item_in[k]  = item_ff[k-1];
         zero_in[k]  = zero_ff[k-1];
         max_in[k]   = max_ff[k-1];
         for (int l = 0; l < LANES; l++) begin
            t  = {rem_ff[k-1][l], low_ff[k-1][l][IW-1]};
            ge = t >= {1'b0, in_den[l]};
            rem_in[k][l] = ge ? DW'(t - {1'b0, in_den[l]}) : t[DW-1:0];
            low_in[k][l] = {low_ff[k-1][l][IW-2:0], 1'b0};
            q_in[k][l]   = {q_ff[k-1][l][IW-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff <= item_in;
         zero_ff <= zero_in;
         max_ff  <= max_in;
         rem_ff  <= rem_in;
         low_ff  <= low_in;
         q_ff    <= q_in;
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         if (zero_ff[STEPS][l]) begin
            out_index[l] = '0;
         end else if (max_ff[STEPS][l]) begin
            out_index[l] = SIZE_M1[l];
         end else begin
            out_index[l] = q_ff[STEPS][l];
         end
      end
   end

   assign out_valid = valid_ff[STEPS];
   assign out_item  = item_ff[STEPS];

endmodule

`default_nettype wire

@@ rtl/core/two_view_density_texel_sampler.sv @@
// Two-view density texel sampler: one item per cycle when the output does not stall, 52-stage pipeline.
// Stages: entry, squares, sum, 32 square-root steps, 13 divider steps,
// two address steps, image read, output register; rsp_ready low with rsp_valid high freezes all.
// Synchronous reset clears valid bits, zeroes box minima and sets box spans to 65536; images keep contents.
// Depends on tvdts_pkg, tvdts_isqrt, tvdts_index_unit, tvdts_image_ram.
`default_nettype none

module two_view_density_texel_sampler #(
   parameter int TOP_WIDTH   = tvdts_pkg::TOP_WIDTH_DEF,
   parameter int TOP_HEIGHT  = tvdts_pkg::TOP_HEIGHT_DEF,
   parameter int SIDE_WIDTH  = tvdts_pkg::SIDE_WIDTH_DEF,
   parameter int SIDE_HEIGHT = tvdts_pkg::SIDE_HEIGHT_DEF,
   parameter int CHANNELS    = tvdts_pkg::CHANNELS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    req_operation,
   input  wire logic [31:0]                   req_point_x,
   input  wire logic [31:0]                   req_point_y,
   input  wire logic [31:0]                   req_point_z,
   input  wire logic [1:0]                    req_channel_index,
   input  wire logic [17:0]                   req_texel_address,
   input  wire logic [7:0]                    req_texel_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [15:0]                   rsp_density_product,
   output logic      [7:0]                    rsp_top_byte,
   output logic      [7:0]                    rsp_side_byte,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [tvdts_pkg::PADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                   csr_pwdata,
   output logic      [31:0]                   csr_prdata,
   output logic                               csr_pready
);

   localparam int AW = tvdts_pkg::ADDR_W;
   localparam int NW = tvdts_pkg::NUM_W;
   localparam int DW = tvdts_pkg::DEN_W;
   localparam int IW = tvdts_pkg::IDX_W;

   // configuration
   logic [31:0] box_min_x_ff, box_min_z_ff;
   logic [30:0] box_span_x_ff, box_span_y_ff, box_span_z_ff;
   logic [2:0]  csr_index;

   assign csr_index  = csr_paddr[4:2];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_min_x_ff  <= '0;
         box_min_z_ff  <= '0;
         box_span_x_ff <= 31'd65536;
         box_span_y_ff <= 31'd65536;
         box_span_z_ff <= 31'd65536;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_index)
            tvdts_pkg::REG_BOX_MIN_X:  box_min_x_ff  <= csr_pwdata;
            tvdts_pkg::REG_BOX_MIN_Z:  box_min_z_ff  <= csr_pwdata;
            tvdts_pkg::REG_BOX_SPAN_X: box_span_x_ff <= csr_pwdata[30:0];
            tvdts_pkg::REG_BOX_SPAN_Y: box_span_y_ff <= csr_pwdata[30:0];
            tvdts_pkg::REG_BOX_SPAN_Z: box_span_z_ff <= csr_pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         tvdts_pkg::REG_BOX_MIN_X:  csr_prdata = box_min_x_ff;
         tvdts_pkg::REG_BOX_MIN_Z:  csr_prdata = box_min_z_ff;
         tvdts_pkg::REG_BOX_SPAN_X: csr_prdata = {1'b0, box_span_x_ff};
         tvdts_pkg::REG_BOX_SPAN_Y: csr_prdata = {1'b0, box_span_y_ff};
         tvdts_pkg::REG_BOX_SPAN_Z: csr_prdata = {1'b0, box_span_z_ff};
         default:                   csr_prdata = '0;
      endcase
   end

   // pipeline control
   logic advance;
   logic rsp_valid_ff;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // entry stage
   tvdts_pkg::sqrt_side_type s0_side_in, s0_side_ff;
   logic                     s0_valid_ff;
   logic [31:0]              s0_px_ff, s0_pz_ff;

   always_comb begin
      s0_side_in.item.op    = tvdts_pkg::op_type'(req_operation);
      s0_side_in.item.ch    = (req_channel_index > 2'(CHANNELS - 1)) ?
                              2'(CHANNELS - 1) : req_channel_index;
      s0_side_in.item.addr  = req_texel_address;
      s0_side_in.item.value = req_texel_value;
      s0_side_in.relx = {{2{req_point_x[31]}}, req_point_x}
                      - {{2{box_min_x_ff[31]}}, box_min_x_ff};
      s0_side_in.relz = {{2{req_point_z[31]}}, req_point_z}
                      - {{2{box_min_z_ff[31]}}, box_min_z_ff};
      s0_side_in.ynum = {req_point_y[31], req_point_y, 1'b0} + {3'b000, box_span_y_ff};
   end

   // squares and sum stages
   logic                     s1_valid_ff, s2_valid_ff;
   tvdts_pkg::sqrt_side_type s1_side_ff, s2_side_ff;
   logic [31:0]              mag_x, mag_z;
   logic [63:0]              s1_sqx_ff, s1_sqz_ff, s2_n_ff;

   assign mag_x = s0_px_ff[31] ? (~s0_px_ff + 32'd1) : s0_px_ff;
   assign mag_z = s0_pz_ff[31] ? (~s0_pz_ff + 32'd1) : s0_pz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_valid;
         s1_valid_ff <= s0_valid_ff;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_side_ff <= s0_side_in;
         s0_px_ff   <= req_point_x;
         s0_pz_ff   <= req_point_z;
         s1_side_ff <= s0_side_ff;
         s1_sqx_ff  <= 64'(mag_x) * 64'(mag_x);
         s1_sqz_ff  <= 64'(mag_z) * 64'(mag_z);
         s2_side_ff <= s1_side_ff;
         s2_n_ff    <= s1_sqx_ff + s1_sqz_ff;
      end
   end

   // radius
   logic                         sq_valid;
   logic [tvdts_pkg::ROOT_W-1:0] sq_root;
   tvdts_pkg::sqrt_side_type     sq_side;

   tvdts_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s2_valid_ff),
      .in_n      (s2_n_ff),
      .in_side   (s2_side_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // texel indexes
   logic [tvdts_pkg::LANES-1:0][NW-1:0] ix_num;
   logic [tvdts_pkg::LANES-1:0][DW-1:0] ix_den;
   logic [tvdts_pkg::LANES-1:0][IW-1:0] ix_index;
   logic                                ix_valid;
   tvdts_pkg::item_type                 ix_item;

   assign ix_num[0] = sq_side.relx;
   assign ix_num[1] = sq_side.relz;
   assign ix_num[2] = {1'b0, sq_root, 1'b0};
   assign ix_num[3] = sq_side.ynum;
   assign ix_den[0] = {1'b0, box_span_x_ff};
   assign ix_den[1] = {1'b0, box_span_z_ff};
   assign ix_den[2] = {1'b0, box_span_x_ff};
   assign ix_den[3] = {box_span_y_ff, 1'b0};

   tvdts_index_unit #(
      .TOP_WIDTH   (TOP_WIDTH),
      .TOP_HEIGHT  (TOP_HEIGHT),
      .SIDE_WIDTH  (SIDE_WIDTH),
      .SIDE_HEIGHT (SIDE_HEIGHT)
   ) u_index_unit (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (sq_valid),
      .in_item   (sq_side.item),
      .in_num    (ix_num),
      .in_den    (ix_den),
      .out_valid (ix_valid),
      .out_item  (ix_item),
      .out_index (ix_index)
   );

   // address stages
   logic                m1_valid_ff, m2_valid_ff, m3_valid_ff;
   tvdts_pkg::item_type m1_item_ff, m2_item_ff;
   logic                m3_sample_ff;
   logic [AW-1:0]       m1_row_top_ff, m1_row_side_ff;
   logic [AW-1:0]       m2_addr_top_ff, m2_addr_side_ff;
   logic [AW-1:0]       addr_top_in, addr_side_in;
   logic                m1_is_sample;

   assign m1_is_sample = m1_item_ff.op == tvdts_pkg::OP_SAMPLE;
   assign addr_top_in  = m1_is_sample ?
      AW'(32'(m1_row_top_ff) * CHANNELS + 32'(m1_item_ff.ch)) : m1_item_ff.addr;
   assign addr_side_in = m1_is_sample ?
      AW'(32'(m1_row_side_ff) * CHANNELS + 32'(m1_item_ff.ch)) : m1_item_ff.addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff  <= 1'b0;
         m2_valid_ff  <= 1'b0;
         m3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         m1_valid_ff  <= ix_valid;
         m2_valid_ff  <= m1_valid_ff;
         m3_valid_ff  <= m2_valid_ff;
         rsp_valid_ff <= m3_valid_ff && m3_sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m1_item_ff      <= ix_item;
         m1_row_top_ff   <= AW'(32'(ix_index[1]) * TOP_WIDTH + 32'(ix_index[0]));
         m1_row_side_ff  <= AW'(32'(ix_index[3]) * SIDE_WIDTH + 32'(ix_index[2]));
         m2_item_ff      <= m1_item_ff;
         m2_addr_top_ff  <= addr_top_in;
         m2_addr_side_ff <= addr_side_in;
         m3_sample_ff    <= m2_item_ff.op == tvdts_pkg::OP_SAMPLE;
      end
   end

   // images
   logic [7:0] top_rdata, side_rdata;

   tvdts_image_ram u_top_image (
      .clock (clock),
      .en    (advance),
      .we    (m2_valid_ff && (m2_item_ff.op == tvdts_pkg::OP_WRITE_TOP)),
      .addr  (m2_addr_top_ff),
      .wdata (m2_item_ff.value),
      .rdata (top_rdata)
   );

   tvdts_image_ram u_side_image (
      .clock (clock),
      .en    (advance),
      .we    (m2_valid_ff && (m2_item_ff.op == tvdts_pkg::OP_WRITE_SIDE)),
      .addr  (m2_addr_side_ff),
      .wdata (m2_item_ff.value),
      .rdata (side_rdata)
   );

   // output register
   logic [15:0] product_ff;
   logic [7:0]  top_byte_ff, side_byte_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         product_ff   <= 16'(top_rdata) * 16'(side_rdata);
         top_byte_ff  <= top_rdata;
         side_byte_ff <= side_rdata;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_density_product = product_ff;
   assign rsp_top_byte        = top_byte_ff;
   assign rsp_side_byte       = side_byte_ff;

endmodule

`default_nettype wire

@@ rtl/core/tvdts_checker.sv @@
// Port-level checker for the two-view density texel sampler, with bind.
// Depends on two_view_density_texel_sampler_defines.svh.
`default_nettype none
`include "two_view_density_texel_sampler_defines.svh"

module tvdts_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] rsp_density_product,
   input wire logic [7:0]  rsp_top_byte,
   input wire logic [7:0]  rsp_side_byte
);

   logic unused_req_valid;
   assign unused_req_valid = req_valid;

   `TVDTS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_density_product) && $stable(rsp_top_byte) && $stable(rsp_side_byte), "stalled transaction changed")

   `TVDTS_ASSERT_SAME(a_product, rsp_valid, rsp_density_product == 16'(rsp_top_byte) * 16'(rsp_side_byte), "product does not match bytes")

   `TVDTS_ASSERT_SAME(a_ready, 1'b1, req_ready == (!rsp_valid || rsp_ready), "req_ready not tied to output stall")

endmodule

bind two_view_density_texel_sampler tvdts_checker u_tvdts_checker (.*);

`default_nettype wire

@@ dv/tb_two_view_density_texel_sampler.sv @@
// Self-checking testbench for two_view_density_texel_sampler: directed and random
// samples and texel writes over several box settings, checked in order against a predictor.
// Depends on tvdts_pkg and the RTL of the block.
`default_nettype none

module tb_two_view_density_texel_sampler;

   localparam int TW = tvdts_pkg::TOP_WIDTH_DEF;
   localparam int TH = tvdts_pkg::TOP_HEIGHT_DEF;
   localparam int SW = tvdts_pkg::SIDE_WIDTH_DEF;
   localparam int SH = tvdts_pkg::SIDE_HEIGHT_DEF;
   localparam int NCH = tvdts_pkg::CHANNELS_DEF;
   localparam int PW = tvdts_pkg::PADDR_W;
   localparam int DRAIN = 60;

   typedef struct {
      tvdts_pkg::op_type op;
      logic [31:0]       px, py, pz;
      logic [1:0]        ch;
      logic [17:0]       addr;
      logic [7:0]        value;
   } txn_type;

   typedef struct {
      logic [15:0] product;
      logic [7:0]  top;
      logic [7:0]  side;
   } density_type;

   logic clock, reset;
   logic req_valid, req_ready;
   logic [1:0] req_operation, req_channel_index;
   logic [31:0] req_point_x, req_point_y, req_point_z;
   logic [17:0] req_texel_address;
   logic [7:0] req_texel_value;
   logic rsp_valid, rsp_ready;
   logic [15:0] rsp_density_product;
   logic [7:0] rsp_top_byte, rsp_side_byte;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [PW-1:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic csr_pready;

   two_view_density_texel_sampler uut (.*);

   txn_type pending_txns[$];
   density_type expected_densities[$];
   logic [7:0] top_texels[int];
   logic [7:0] side_texels[int];
   longint min_x, min_z;
   longint unsigned span_x, span_y, span_z;
   int errors = 0;
   bit calm = 0;
   int req_gap = 0, rsp_stall = 0;

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      #(8 * 3000000);
      $display("** two_view_density_texel_sampler: FAILED **");
      $finish;
   end

   function automatic longint unsigned scaled_idx(longint num, longint unsigned den, int size);
      longint unsigned q;
      if (num <= 0) return 0;
      if (den == 0) return size - 1;
      q = (longint'(num) * (size - 1)) / den;
      return (q > size - 1) ? size - 1 : q;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res = 0, bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint unsigned magnitude(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic void push_write(tvdts_pkg::op_type op, logic [17:0] addr,
                                      logic [7:0] value);
      txn_type t;
      t = '{op: op, px: $urandom, py: $urandom, pz: $urandom, ch: 2'($urandom),
            addr: addr, value: value};
      if (op == tvdts_pkg::OP_WRITE_TOP) top_texels[addr] = value;
      else if (op == tvdts_pkg::OP_WRITE_SIDE) side_texels[addr] = value;
      pending_txns.push_back(t);
   endfunction

   // unwritten texels on the sample's path are loaded first
   function automatic void push_sample(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                       logic [1:0] ch);
      longint x, y, z;
      longint unsigned tx, tz, sx, sy, r, chs;
      int ta, sa;
      txn_type t;
      density_type d;
      x = longint'(signed'(px));
      y = longint'(signed'(py));
      z = longint'(signed'(pz));
      chs = (ch > NCH - 1) ? NCH - 1 : ch;
      tx = scaled_idx(x - min_x, span_x, TW);
      tz = scaled_idx(z - min_z, span_z, TH);
      r = int_sqrt(magnitude(x) * magnitude(x) + magnitude(z) * magnitude(z));
      sx = scaled_idx(longint'(2 * r), span_x, SW);
      sy = scaled_idx(2 * y + longint'(span_y), 2 * span_y, SH);
      ta = int'(((tz * TW + tx) * NCH + chs) & 18'h3FFFF);
      sa = int'(((sy * SW + sx) * NCH + chs) & 18'h3FFFF);
      if (!top_texels.exists(ta))
         push_write(tvdts_pkg::OP_WRITE_TOP, ta[17:0], 8'($urandom));
      if (!side_texels.exists(sa))
         push_write(tvdts_pkg::OP_WRITE_SIDE, sa[17:0], 8'($urandom));
      t = '{op: tvdts_pkg::OP_SAMPLE, px: px, py: py, pz: pz, ch: ch,
            addr: 18'($urandom), value: 8'($urandom)};
      pending_txns.push_back(t);
      d.top = top_texels[ta];
      d.side = side_texels[sa];
      d.product = 16'(d.top) * 16'(d.side);
      expected_densities.push_back(d);
   endfunction

   function automatic void push_ignored();
      txn_type t;
      t = '{op: tvdts_pkg::OP_IGNORE, px: $urandom, py: $urandom, pz: $urandom,
            ch: 2'($urandom), addr: 18'($urandom), value: 8'($urandom)};
      pending_txns.push_back(t);
   endfunction

   function automatic logic [31:0] coord_in(longint lo, longint unsigned span);
      longint v;
      v = lo + longint'($urandom_range(0, 32'(span)));
      return v[31:0];
   endfunction

   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= PW'(idx) << 2;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      case (idx)
         tvdts_pkg::REG_BOX_MIN_X: min_x = longint'(signed'(value));
         tvdts_pkg::REG_BOX_MIN_Z: min_z = longint'(signed'(value));
         tvdts_pkg::REG_BOX_SPAN_X: span_x = value[30:0];
         tvdts_pkg::REG_BOX_SPAN_Y: span_y = value[30:0];
         tvdts_pkg::REG_BOX_SPAN_Z: span_z = value[30:0];
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      while (pending_txns.size() != 0 || req_valid || expected_densities.size() != 0)
         @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic run_random(int count);
      int kind;
      logic [31:0] px, py, pz;
      for (int i = 0; i < count; i++) begin
         kind = $urandom_range(0, 99);
         if (kind < 60) begin
            if ($urandom_range(0, 2) != 0) begin
               px = coord_in(min_x, span_x);
               pz = coord_in(min_z, span_z);
               py = coord_in(-longint'(span_y / 2), span_y);
            end else begin
               px = $urandom;
               py = $urandom;
               pz = $urandom;
            end
            push_sample(px, py, pz, 2'($urandom));
         end else if (kind < 90) begin
            push_write(kind[0] ? tvdts_pkg::OP_WRITE_TOP : tvdts_pkg::OP_WRITE_SIDE,
                       18'($urandom), 8'($urandom));
         end else begin
            push_ignored();
         end
         if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      end
   endtask

   initial begin
      reset = 1;
      req_valid = 0;
      req_operation = tvdts_pkg::OP_IGNORE;
      req_point_x = 0;
      req_point_y = 0;
      req_point_z = 0;
      req_channel_index = 0;
      req_texel_address = 0;
      req_texel_value = 0;
      rsp_ready = 0;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = 0;
      csr_pwdata = 0;
      min_x = 0;
      min_z = 0;
      span_x = 65536;
      span_y = 65536;
      span_z = 65536;
      repeat (11) @(posedge clock);
      reset <= 0;

      // directed: address and value extremes, point extremes, every channel, ignored op
      push_write(tvdts_pkg::OP_WRITE_TOP, 18'h00000, 8'h00);
      push_write(tvdts_pkg::OP_WRITE_TOP, 18'h3FFFF, 8'hFF);
      push_write(tvdts_pkg::OP_WRITE_SIDE, 18'h00000, 8'hFF);
      push_write(tvdts_pkg::OP_WRITE_SIDE, 18'h3FFFF, 8'h00);
      push_sample(32'h0, 32'h0, 32'h0, 2'd0);
      push_sample(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 2'd3);
      push_sample(32'h80000000, 32'h80000000, 32'h80000000, 2'd1);
      push_sample(32'h80000000, 32'h0, 32'h7FFFFFFF, 2'd2);
      push_sample(32'h0000FFFF, 32'hFFFF8000, 32'h00008000, 2'd3);
      push_sample(32'h00010000, 32'h00008000, 32'h00010000, 2'd0);
      push_sample(32'hFFFFFFFF, 32'h00007FFF, 32'h00000001, 2'd1);
      push_ignored();
      push_sample(32'h00004000, 32'h0, 32'h00004000, 2'd2);
      wait_idle();
      run_random(60);
      wait_idle();

      write_reg(tvdts_pkg::REG_BOX_MIN_X, 32'h80000000);
      write_reg(tvdts_pkg::REG_BOX_MIN_Z, 32'h80000000);
      write_reg(tvdts_pkg::REG_BOX_SPAN_X, 32'h7FFFFFFF);
      write_reg(tvdts_pkg::REG_BOX_SPAN_Y, 32'h7FFFFFFF);
      write_reg(tvdts_pkg::REG_BOX_SPAN_Z, 32'h7FFFFFFF);
      run_random(70);
      wait_idle();

      write_reg(tvdts_pkg::REG_BOX_MIN_X, 32'h7FFFFFFF);
      write_reg(tvdts_pkg::REG_BOX_MIN_Z, 32'h7FFFFFFF);
      write_reg(tvdts_pkg::REG_BOX_SPAN_X, 32'h1);
      write_reg(tvdts_pkg::REG_BOX_SPAN_Y, 32'h1);
      write_reg(tvdts_pkg::REG_BOX_SPAN_Z, 32'h1);
      run_random(60);
      wait_idle();

      for (int phase = 0; phase < 3; phase++) begin
         write_reg(tvdts_pkg::REG_BOX_MIN_X, -$urandom_range(0, 32'h00040000));
         write_reg(tvdts_pkg::REG_BOX_MIN_Z, -$urandom_range(0, 32'h00040000));
         write_reg(tvdts_pkg::REG_BOX_SPAN_X, $urandom_range(1, 32'h00080000));
         write_reg(tvdts_pkg::REG_BOX_SPAN_Y, $urandom_range(1, 32'h00080000));
         write_reg(tvdts_pkg::REG_BOX_SPAN_Z, $urandom_range(1, 32'h00080000));
         run_random(60);
         wait_idle();
      end

      if (errors == 0)
         $display("** two_view_density_texel_sampler: PASSED **");
      else
         $display("** two_view_density_texel_sampler: FAILED **");
      $finish;
   end

   always @(posedge clock) begin
      txn_type t;
      if (reset) begin
         req_valid <= 0;
      end else if (!(req_valid && !req_ready)) begin
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_valid <= 0;
         end else if (pending_txns.size() != 0) begin
            t = pending_txns.pop_front();
            req_valid <= 1;
            req_operation <= t.op;
            req_point_x <= t.px;
            req_point_y <= t.py;
            req_point_z <= t.pz;
            req_channel_index <= t.ch;
            req_texel_address <= t.addr;
            req_texel_value <= t.value;
            req_gap <= calm ? 0 : $urandom_range(0, 17);
         end else begin
            req_valid <= 0;
         end
      end
   end

   always @(posedge clock) begin
      density_type d;
      int stall;
      stall = rsp_stall;
      if (reset) begin
         rsp_ready <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            stall = calm ? 0 : $urandom_range(0, 17);
            if (expected_densities.size() == 0) begin
               $error("unexpected transaction: product %0d", rsp_density_product);
               errors++;
            end else begin
               d = expected_densities.pop_front();
               if (rsp_density_product !== d.product) begin
                  $error("density_product: expected %0d, got %0d", d.product,
                         rsp_density_product);
                  errors++;
               end
               if (rsp_top_byte !== d.top) begin
                  $error("top_byte: expected %0d, got %0d", d.top, rsp_top_byte);
                  errors++;
               end
               if (rsp_side_byte !== d.side) begin
                  $error("side_byte: expected %0d, got %0d", d.side, rsp_side_byte);
                  errors++;
               end
            end
         end
         if (stall > 0) begin
            rsp_ready <= 0;
            rsp_stall <= stall - 1;
         end else begin
            rsp_ready <= 1;
            rsp_stall <= 0;
         end
      end
   end

endmodule

`default_nettype wire

@@ two_view_density_texel_sampler.f @@
+incdir+rtl/core
rtl/core/tvdts_pkg.sv
rtl/core/tvdts_image_ram.sv
rtl/core/tvdts_isqrt.sv
rtl/core/tvdts_index_unit.sv
rtl/core/two_view_density_texel_sampler.sv
rtl/core/tvdts_checker.sv
dv/tb_two_view_density_texel_sampler.sv
